// ----- sv/sst_pkg.sv -----
// Shared types, codes and defaults for the scoped symbol table.
package sst_pkg;

   localparam int DEF_KEY_BITS     = 32;
   localparam int DEF_VALUE_BITS   = 32;
   localparam int DEF_MAX_BINDINGS = 64;
   localparam int DEF_MAX_SCOPES   = 16;

   // Fixed field widths on the ports
   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 3;
   localparam int FSCOPE_W = 4;
   localparam int DEPTH_W  = 5;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [OP_W-1:0] {
      OP_OPEN   = 2'd0,
      OP_CLOSE  = 2'd1,
      OP_INSERT = 2'd2,
      OP_LOOKUP = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NO_SCOPE = 3'd1,
      ST_DUP_KEY  = 3'd2,
      ST_FULL     = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_EVAL,
      S_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;        // capture request, clear result, ptr <= count
      logic       open_scope;  // open_scopes + 1
      logic       close_scope; // open_scopes - 1, count <= ptr (+ keep)
      logic       keep;        // entry under examination survives the close
      logic       insert;      // write binding at count, count + 1
      logic       read;        // read entry ptr-1, ptr - 1
      logic       set_status;
      status_type status;
      logic       set_found;   // latch entry just read as the lookup hit
      logic       finish;      // move result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      opcode_type op;
      logic       scopes_zero;
      logic       scopes_full;
      logic       count_full;
      logic       ptr_zero;
      logic       ent_top;     // entry just read belongs to innermost scope
      logic       key_match;   // entry just read carries the request key
      logic       out_free;
   } dp_status_type;

endpackage

// ----- sv/sst_ctrl.sv -----
// Sequencer for the scoped symbol table: decides each step of an operation.
module sst_ctrl
   import sst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type st,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            unique case (st.op)
               OP_OPEN:   state_in = S_FINISH;
               OP_CLOSE:  state_in = (st.scopes_zero || st.ptr_zero) ? S_FINISH : S_EVAL;
               OP_INSERT: state_in = (st.scopes_zero || st.ptr_zero) ? S_FINISH : S_EVAL;
               OP_LOOKUP: state_in = st.ptr_zero ? S_FINISH : S_EVAL;
               default:   state_in = S_FINISH;
            endcase
         end
         S_EVAL: begin
            unique case (st.op)
               OP_CLOSE: begin
                  state_in = (st.ent_top && !st.ptr_zero) ? S_EVAL : S_FINISH;
               end
               OP_INSERT: begin
                  state_in = (st.ent_top && !st.key_match && !st.ptr_zero) ? S_EVAL : S_FINISH;
               end
               OP_LOOKUP: begin
                  state_in = (!st.key_match && !st.ptr_zero) ? S_EVAL : S_FINISH;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_FINISH: begin
            if (st.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      cmd.status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_DECIDE: begin
            unique case (st.op)
               OP_OPEN: begin
                  if (st.scopes_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_OVERFLOW;
                  end else begin
                     cmd.open_scope = 1'b1;
                  end
               end
               OP_CLOSE: begin
                  if (st.scopes_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_NO_SCOPE;
                  end else if (st.ptr_zero) begin
                     cmd.close_scope = 1'b1;
                  end else begin
                     cmd.read = 1'b1;
                  end
               end
               OP_INSERT: begin
                  if (st.scopes_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_NO_SCOPE;
                  end else if (!st.ptr_zero) begin
                     cmd.read = 1'b1;
                  end else if (st.count_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.insert = 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  cmd.read = !st.ptr_zero;
               end
               default: cmd.read = 1'b0;
            endcase
         end
         S_EVAL: begin
            unique case (st.op)
               OP_CLOSE: begin
                  if (st.ent_top && !st.ptr_zero) begin
                     cmd.read = 1'b1;
                  end else begin
                     cmd.close_scope = 1'b1;
                     cmd.keep        = !st.ent_top;
                  end
               end
               OP_INSERT: begin
                  if (st.ent_top && st.key_match) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_DUP_KEY;
                  end else if (st.ent_top && !st.ptr_zero) begin
                     cmd.read = 1'b1;
                  end else if (st.count_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.insert = 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  if (st.key_match) begin
                     cmd.set_found = 1'b1;
                  end else if (!st.ptr_zero) begin
                     cmd.read = 1'b1;
                  end
               end
               default: cmd.read = 1'b0;
            endcase
         end
         S_FINISH: begin
            cmd.finish = st.out_free;
         end
         default: req_tready = 1'b0;
      endcase
   end

endmodule

// ----- sv/sst_dpath.sv -----
// Binding stack memories, scan pointer, counters and the result register.
module sst_dpath
   import sst_pkg::*;
#(
   parameter int KEY_BITS     = DEF_KEY_BITS,
   parameter int VALUE_BITS   = DEF_VALUE_BITS,
   parameter int MAX_BINDINGS = DEF_MAX_BINDINGS,
   parameter int MAX_SCOPES   = DEF_MAX_SCOPES
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  cmd_type               cmd,
   output dp_status_type         st
);

   localparam int IDX_W = $clog2(MAX_BINDINGS);
   localparam int CNT_W = $clog2(MAX_BINDINGS + 1);
   localparam int LVL_W = $clog2(MAX_SCOPES);
   localparam int SCP_W = $clog2(MAX_SCOPES + 1);

   // Binding stack
   logic [KEY_BITS-1:0]   key_mem [MAX_BINDINGS];
   logic [VALUE_BITS-1:0] val_mem [MAX_BINDINGS];
   logic [LVL_W-1:0]      lvl_mem [MAX_BINDINGS];

   logic [CNT_W-1:0] count_ff,  count_in;
   logic [CNT_W-1:0] ptr_ff,    ptr_in;
   logic [SCP_W-1:0] scopes_ff, scopes_in;

   opcode_type          op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [VALUE_BITS-1:0] val_ff;

   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [VALUE_BITS-1:0] rd_val_ff;
   logic [LVL_W-1:0]      rd_lvl_ff;

   status_type          status_ff;
   logic                found_ff;
   logic [VAL_W-1:0]    fval_ff;
   logic [FSCOPE_W-1:0] fscope_ff;
   logic                incur_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [CNT_W-1:0] ptr_dec;
   logic [LVL_W-1:0] top_lvl;
   logic [SCP_W-1:0] scopes_dec;

   assign ptr_dec    = ptr_ff - 1'b1;
   assign scopes_dec = scopes_ff - 1'b1;
   assign top_lvl    = scopes_dec[LVL_W-1:0];

   assign st.op          = op_ff;
   assign st.scopes_zero = (scopes_ff == '0);
   assign st.scopes_full = (scopes_ff == SCP_W'(MAX_SCOPES));
   assign st.count_full  = (count_ff == CNT_W'(MAX_BINDINGS));
   assign st.ptr_zero    = (ptr_ff == '0);
   assign st.ent_top     = (scopes_ff != '0) && (rd_lvl_ff == top_lvl);
   assign st.key_match   = (rd_key_ff == key_ff);
   assign st.out_free    = !rsp_valid_ff || rsp_tready;

   // Memory write at the stack top, registered read below the scan pointer
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         key_mem[count_ff[IDX_W-1:0]] <= key_ff;
         val_mem[count_ff[IDX_W-1:0]] <= val_ff;
         lvl_mem[count_ff[IDX_W-1:0]] <= top_lvl;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_key_ff <= key_mem[ptr_dec[IDX_W-1:0]];
         rd_val_ff <= val_mem[ptr_dec[IDX_W-1:0]];
         rd_lvl_ff <= lvl_mem[ptr_dec[IDX_W-1:0]];
      end
   end

   always_comb begin
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      scopes_in = scopes_ff;
      if (cmd.load)        ptr_in    = count_ff;
      if (cmd.read)        ptr_in    = ptr_dec;
      if (cmd.open_scope)  scopes_in = scopes_ff + 1'b1;
      if (cmd.close_scope) begin
         scopes_in = scopes_dec;
         count_in  = ptr_ff + CNT_W'(cmd.keep);
      end
      if (cmd.insert)      count_in  = count_ff + 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         scopes_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         scopes_ff    <= scopes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= opcode_type'(req_tuser);
         key_ff    <= KEY_BITS'(req_tdata[KEY_W-1:0]);
         val_ff    <= VALUE_BITS'(req_tdata[KEY_W+VAL_W-1:KEY_W]);
         status_ff <= ST_OK;
         found_ff  <= 1'b0;
         fval_ff   <= '0;
         fscope_ff <= '0;
         incur_ff  <= 1'b0;
      end else begin
         if (cmd.set_status) status_ff <= cmd.status;
         if (cmd.set_found) begin
            found_ff  <= 1'b1;
            fval_ff   <= VAL_W'(rd_val_ff);
            fscope_ff <= FSCOPE_W'(rd_lvl_ff);
            incur_ff  <= st.ent_top;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {2'b00, DEPTH_W'(scopes_ff), incur_ff, fscope_ff, fval_ff,
                         found_ff, status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BINDINGS))
      else $error("binding count beyond table size");

   a_scope_bound: assert property (@(posedge clock) disable iff (reset)
      scopes_ff <= SCP_W'(MAX_SCOPES))
      else $error("open scope count beyond limit");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> (ptr_ff != '0))
      else $error("stack read below entry zero");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> (count_ff != CNT_W'(MAX_BINDINGS)) && (scopes_ff != '0))
      else $error("insert into full table or with no scope");

   a_ptr_within_count: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff)
      else $error("scan pointer above stack top");
`endif

endmodule

// ----- sv/scoped_symbol_table_top.sv -----
// Scoped symbol table: stream request in, one stream response out per request.
//
// A nested-scope symbol table. Each request item carries an opcode on req_tuser (0 open
// scope, 1 close innermost scope, 2 insert key/value into the innermost scope, 3 look up a
// key) and key and value on req_tdata; every request yields exactly one response item.
// Bindings live on one stack tagged with their scope level; a lookup returns the newest
// binding of a key, its level and whether it lies in the innermost scope, and closing a
// scope drops every binding it made. Errors come back as status codes and change nothing.
// One request is handled at a time. Close, insert and lookup examine stack entries one
// per cycle through the registered read port of the binding memory: close and insert
// walk the entries of the innermost scope from the top, a lookup walks down until the
// first key match (at most MAX_BINDINGS entries). A finished response waits in an output
// register, so the next request is taken while it is still unread. No clearing pass is
// needed after reset: only entries below the live count are ever read.
module scoped_symbol_table_top
   import sst_pkg::*;
#(
   parameter int KEY_BITS     = DEF_KEY_BITS,
   parameter int VALUE_BITS   = DEF_VALUE_BITS,
   parameter int MAX_BINDINGS = DEF_MAX_BINDINGS,
   parameter int MAX_SCOPES   = DEF_MAX_SCOPES
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key[31:0], value[63:32]
   input  logic [OP_W-1:0]       req_tuser,   // opcode[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // status[2:0], found[3], found_value[35:4],
                                              // found_scope[39:36], in_current_scope[40],
                                              // scope_depth[45:41], zero[47:46]
);

   cmd_type       cmd;
   dp_status_type st;

   // Sequencer: steps each operation, one stack entry per cycle
   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   // Binding stack, counters and the response register
   sst_dpath #(
      .KEY_BITS     (KEY_BITS),
      .VALUE_BITS   (VALUE_BITS),
      .MAX_BINDINGS (MAX_BINDINGS),
      .MAX_SCOPES   (MAX_SCOPES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

// ----- verif/scoped_symbol_table_top_tb.sv -----
// Self-checking testbench for the scoped symbol table: directed cases, then random traffic.
module scoped_symbol_table_top_tb;
   import sst_pkg::*;

   localparam int MAX_BIND    = DEF_MAX_BINDINGS;
   localparam int MAX_SC      = DEF_MAX_SCOPES;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_WAIT  = MAX_BIND + 16;   // longest walk plus overhead
   localparam int POOL_SIZE   = 10;

   // One response item, field for field
   typedef struct packed {
      status_type          status;
      logic                found;
      logic [VAL_W-1:0]    found_value;
      logic [FSCOPE_W-1:0] found_scope;
      logic                in_current_scope;
      logic [DEPTH_W-1:0]  scope_depth;
   } sym_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = OP_OPEN;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   scoped_symbol_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Shadow copy of the binding stack, advanced at each accepted request
   logic [KEY_W-1:0] shadow_key [MAX_BIND];
   logic [VAL_W-1:0] shadow_val [MAX_BIND];
   int               shadow_lvl [MAX_BIND];
   int               live_count = 0;
   int               open_count = 0;

   sym_result_type   expected_results[$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   int               mismatches = 0;
   int               cycle_count = 0;
   bit               send_gaps = 1'b1;
   bit               recv_gaps = 1'b1;
   int               rsp_hold = 0;

   // Apply one request to the shadow table and return the response it must produce.
   function automatic sym_result_type table_apply(opcode_type op, logic [KEY_W-1:0] k,
                                                  logic [VAL_W-1:0] v);
      sym_result_type r;
      bit             dup;
      int             i;
      r        = '0;
      r.status = ST_OK;
      dup      = 1'b0;
      case (op)
         OP_OPEN: begin
            if (open_count >= MAX_SC) r.status = ST_OVERFLOW;
            else open_count++;
         end
         OP_CLOSE: begin
            if (open_count == 0) begin
               r.status = ST_NO_SCOPE;
            end else begin
               // drop every binding made in the innermost scope
               while (live_count > 0 && shadow_lvl[live_count-1] == open_count - 1)
                  live_count--;
               open_count--;
            end
         end
         OP_INSERT: begin
            if (open_count == 0) begin
               r.status = ST_NO_SCOPE;
            end else begin
               for (i = 0; i < live_count; i++)
                  if (shadow_lvl[i] == open_count - 1 && shadow_key[i] == k) dup = 1'b1;
               // duplicate check wins over the full check
               if (dup) begin
                  r.status = ST_DUP_KEY;
               end else if (live_count >= MAX_BIND) begin
                  r.status = ST_FULL;
               end else begin
                  shadow_key[live_count] = k;
                  shadow_val[live_count] = v;
                  shadow_lvl[live_count] = open_count - 1;
                  live_count++;
               end
            end
         end
         default: begin
            // newest binding first; it shadows all older ones
            for (i = live_count - 1; i >= 0 && !r.found; i--) begin
               if (shadow_key[i] == k) begin
                  r.found            = 1'b1;
                  r.found_value      = shadow_val[i];
                  r.found_scope      = FSCOPE_W'(shadow_lvl[i]);
                  r.in_current_scope = (shadow_lvl[i] == open_count - 1);
               end
            end
         end
      endcase
      r.scope_depth = DEPTH_W'(open_count);
      return r;
   endfunction

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      else if (r < 92) return $urandom_range(3, 1);
      else return $urandom_range(24, 4);
   endfunction

   // Keys: pool keys give shadowing and duplicates, live keys give hits, raw keys give misses
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 55) return key_pool[$urandom_range(POOL_SIZE-1)];
      else if (r < 80 && live_count > 0) return shadow_key[$urandom_range(live_count-1)];
      else return $urandom;
   endfunction

   // Growing profile drives the table toward full and deep; shrinking pulls it back.
   function automatic opcode_type pick_op(bit grow);
      int r;
      r = $urandom_range(99);
      if (open_count == 0 && r < 70) return OP_OPEN;
      if (grow) begin
         if (r < 20) return OP_OPEN;
         else if (r < 28) return OP_CLOSE;
         else if (r < 68) return OP_INSERT;
         else return OP_LOOKUP;
      end else begin
         if (r < 8) return OP_OPEN;
         else if (r < 35) return OP_CLOSE;
         else if (r < 60) return OP_INSERT;
         else return OP_LOOKUP;
      end
   endfunction

   // Drive one request item at the falling edge, hold it until accepted, then predict.
   // Valid is left high on return; the next call or a drain decides what follows.
   task automatic send_item(input opcode_type op, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v);
      int gap;
      gap = send_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v, k};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(table_apply(op, k, v));
      @(negedge clock);
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      @(negedge clock);
   endtask

   // Lookup, close and insert on a table with no open scope
   task automatic test_empty_table();
      send_item(OP_LOOKUP, key_pool[0], $urandom);
      send_item(OP_CLOSE, $urandom, $urandom);
      send_item(OP_INSERT, key_pool[1], $urandom);
   endtask

   // Field extremes, duplicates, shadowing across two levels and unbinding on close
   task automatic test_shadowing();
      send_item(OP_OPEN, '1, '1);
      send_item(OP_INSERT, '0, '1);
      send_item(OP_INSERT, '1, '0);
      send_item(OP_INSERT, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
      send_item(OP_INSERT, '0, 32'h1234_5678);          // duplicate in this scope
      send_item(OP_LOOKUP, '0, '0);
      send_item(OP_LOOKUP, '1, '1);
      send_item(OP_LOOKUP, 32'h5A5A_A5A5, '0);          // never bound
      send_item(OP_OPEN, '0, '0);
      send_item(OP_INSERT, '0, $urandom);               // shadows the outer binding
      send_item(OP_LOOKUP, '0, '0);
      send_item(OP_LOOKUP, '1, '0);                     // outer level, not current
      send_item(OP_CLOSE, '0, '0);
      send_item(OP_LOOKUP, '0, '0);                     // outer binding visible again
      send_item(OP_CLOSE, '1, '1);
      send_item(OP_LOOKUP, '0, '0);                     // all bindings gone
   endtask

   // Open every level, one past the limit, then unwind below zero
   task automatic test_scope_overflow();
      drain();
      send_gaps = 1'b0;
      while (open_count < MAX_SC) begin
         send_item(OP_OPEN, $urandom, $urandom);
         if ($urandom_range(1)) send_item(OP_INSERT, pick_key(), $urandom);
      end
      send_item(OP_OPEN, $urandom, $urandom);
      send_item(OP_INSERT, key_pool[2], $urandom);
      send_item(OP_LOOKUP, key_pool[2], $urandom);
      send_gaps = 1'b1;
      while (open_count > 0) begin
         send_item(OP_LOOKUP, pick_key(), $urandom);
         send_item(OP_CLOSE, $urandom, $urandom);
      end
      send_item(OP_CLOSE, $urandom, $urandom);
   endtask

   // Fill the stack across two levels, then hit the duplicate and full cases
   task automatic test_table_full();
      int i;
      send_item(OP_OPEN, $urandom, $urandom);
      for (i = 0; i < MAX_BIND; i++) begin
         if (i == MAX_BIND / 2) send_item(OP_OPEN, $urandom, $urandom);
         send_item(OP_INSERT, ($urandom & ~32'h7F) | KEY_W'(i), $urandom);
      end
      send_item(OP_INSERT, shadow_key[live_count-1], $urandom);   // duplicate beats full
      send_item(OP_INSERT, 32'h0000_0080, $urandom);              // table full
      send_item(OP_LOOKUP, shadow_key[0], $urandom);              // deepest entry
      send_item(OP_OPEN, $urandom, $urandom);
      send_item(OP_INSERT, shadow_key[0], $urandom);              // full in a fresh scope
      while (open_count > 0) send_item(OP_CLOSE, $urandom, $urandom);
   endtask

   // Random traffic in chunks with changing profile and handshake pressure
   task automatic test_random();
      int         chunk;
      int         n;
      opcode_type op;
      for (chunk = 0; chunk < 17; chunk++) begin
         send_gaps = (chunk % 4 != 3);
         recv_gaps = (chunk % 4 != 3) && (chunk % 4 != 1);
         if (chunk % 5 == 4) drain();
         for (n = 0; n < 100; n++) begin
            op = pick_op(chunk % 3 != 1);
            send_item(op, pick_key(), $urandom);
         end
      end
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   // Receiver: stall at random, released at the falling edge
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_hold = recv_gaps ? pick_gap() : 0;
         if (rsp_hold == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rsp_hold = rsp_hold - 1;
         end
      end
   end

   function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                       logic [VAL_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted response item with the oldest expectation
   always @(posedge clock) begin : check_responses
      sym_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("response item with no request outstanding: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", want.status, rsp_tdata[2:0]);
            check_field("found", want.found, rsp_tdata[3]);
            check_field("found_value", want.found_value, rsp_tdata[35:4]);
            check_field("found_scope", want.found_scope, rsp_tdata[39:36]);
            check_field("in_current_scope", want.in_current_scope, rsp_tdata[40]);
            check_field("scope_depth", want.scope_depth, rsp_tdata[45:41]);
            check_field("pad", '0, rsp_tdata[47:46]);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("scoped_symbol_table_top_tb: FAIL");
         $finish;
      end
   end

   initial begin
      int i;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_shadowing();
      test_scope_overflow();
      test_table_full();
      test_random();

      // let the last responses out, then allow for a late stray item
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d responses never arrived", expected_results.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("scoped_symbol_table_top_tb: PASS");
      end else begin
         $display("scoped_symbol_table_top_tb: FAIL");
      end
      $finish;
   end

endmodule
